@@ src/pip_pkg.sv @@
// Shared constants and types for the point-in-polygon test block.
package pip_pkg;

    // Default coordinate width (signed Q16.8)
    localparam int COORD_WIDTH_DEF = 24;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Vertex counter, saturating at three
    localparam int COUNT_WIDTH = 2;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = 2'd1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = 2'd3;

    // Slot order of the coordinates carried in one queued task word
    localparam int C_SY     = 0;
    localparam int C_SX     = 1;
    localparam int C_VY     = 2;
    localparam int C_VX     = 3;
    localparam int C_PY     = 4;
    localparam int C_PX     = 5;
    localparam int C_QY     = 6;
    localparam int C_QX     = 7;
    localparam int N_COORDS = 8;

    // Edge slots handled by the back end per task
    localparam int EDGE_OPEN  = 0;
    localparam int EDGE_CLOSE = 1;
    localparam int N_EDGES    = 2;

    // Control flags of one task passed from front to back
    typedef struct packed {
        logic edge_a;    // previous vertex to current vertex
        logic edge_b;    // closing edge, current vertex to first vertex
        logic first;     // restart the accumulators
        logic last;      // emit a result word
        logic excl;      // boundary test disabled
        logic count_ok;  // at least three vertices seen
    } pip_ctrl_t;

endpackage

@@ src/pip_vertex_if.sv @@
// Input channel carrying one polygon vertex word.
interface pip_vertex_if
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic                          exclude_boundary;
    logic                          first_vertex;
    logic                          last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, query_x, query_y,
               exclude_boundary, first_vertex, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, query_x, query_y,
               exclude_boundary, first_vertex, last_vertex,
        output ready
    );
endinterface

@@ src/pip_result_if.sv @@
// Output channel carrying one inside/outside result word.
interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

@@ src/pip_front.sv @@
// Front end: holds polygon context and turns each vertex word into an edge task.
module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            q_ready,
    input  logic signed [COORD_WIDTH-1:0]   vertex_x,
    input  logic signed [COORD_WIDTH-1:0]   vertex_y,
    input  logic signed [COORD_WIDTH-1:0]   query_x,
    input  logic signed [COORD_WIDTH-1:0]   query_y,
    input  logic                            exclude_boundary,
    input  logic                            first_vertex,
    input  logic                            last_vertex,
    output logic                            push,
    output pip_ctrl_t                       task_ctrl,
    output logic [N_COORDS*COORD_WIDTH-1:0] task_coords
);

    logic [COORD_WIDTH-1:0] start_x_reg, start_x_next;
    logic [COORD_WIDTH-1:0] start_y_reg, start_y_next;
    logic [COORD_WIDTH-1:0] prev_x_reg;
    logic [COORD_WIDTH-1:0] prev_y_reg;
    logic [COORD_WIDTH-1:0] query_x_reg, query_x_next;
    logic [COORD_WIDTH-1:0] query_y_reg, query_y_next;
    logic                   excl_reg, excl_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    assign push = in_valid && q_ready;

    // Effective context for this word: a first vertex brings its own
    always_comb
    begin
        if (first_vertex)
        begin
            start_x_next = vertex_x;
            start_y_next = vertex_y;
            query_x_next = query_x;
            query_y_next = query_y;
            excl_next    = exclude_boundary;
            count_next   = COUNT_ONE;
        end
        else
        begin
            start_x_next = start_x_reg;
            start_y_next = start_y_reg;
            query_x_next = query_x_reg;
            query_y_next = query_y_reg;
            excl_next    = excl_reg;
            count_next   = (count_reg == COUNT_SAT) ? COUNT_SAT
                                                    : count_reg + COUNT_ONE;
        end
    end

    // Task word
    always_comb
    begin
        task_ctrl.edge_a   = !first_vertex;
        task_ctrl.edge_b   = last_vertex;
        task_ctrl.first    = first_vertex;
        task_ctrl.last     = last_vertex;
        task_ctrl.excl     = excl_next;
        task_ctrl.count_ok = (count_next == COUNT_SAT);
        task_coords = '0;
        task_coords[C_SY*COORD_WIDTH +: COORD_WIDTH] = start_y_next;
        task_coords[C_SX*COORD_WIDTH +: COORD_WIDTH] = start_x_next;
        task_coords[C_VY*COORD_WIDTH +: COORD_WIDTH] = vertex_y;
        task_coords[C_VX*COORD_WIDTH +: COORD_WIDTH] = vertex_x;
        task_coords[C_PY*COORD_WIDTH +: COORD_WIDTH] = prev_y_reg;
        task_coords[C_PX*COORD_WIDTH +: COORD_WIDTH] = prev_x_reg;
        task_coords[C_QY*COORD_WIDTH +: COORD_WIDTH] = query_y_next;
        task_coords[C_QX*COORD_WIDTH +: COORD_WIDTH] = query_x_next;
    end

    // Polygon context registers (reset values take part in the result)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            query_x_reg <= '0;
            query_y_reg <= '0;
            excl_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else if (push)
        begin
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            prev_x_reg  <= vertex_x;
            prev_y_reg  <= vertex_y;
            query_x_reg <= query_x_next;
            query_y_reg <= query_y_next;
            excl_reg    <= excl_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ src/pip_queue.sv @@
// Small register queue decoupling the front end from the edge pipeline.
module pip_queue
    import pip_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             wr_ready,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ src/pip_back.sv @@
// Back end: three-stage edge evaluation, parity/boundary accumulation, result register.
module pip_back
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  pip_ctrl_t                       q_ctrl,
    input  logic [N_COORDS*COORD_WIDTH-1:0] q_coords,
    output logic                            pop,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic                            out_inside
);

    localparam int D = COORD_WIDTH + 1;  // difference width
    localparam int P = 2 * D;            // product width
    localparam int S = P + 1;            // sum width

    // Stage enable: the whole pipeline moves unless a result is stuck
    logic en;

    // Edge endpoints from the queue head
    logic signed [COORD_WIDTH-1:0] x1 [N_EDGES];
    logic signed [COORD_WIDTH-1:0] y1 [N_EDGES];
    logic signed [COORD_WIDTH-1:0] x2 [N_EDGES];
    logic signed [COORD_WIDTH-1:0] y2 [N_EDGES];
    logic signed [COORD_WIDTH-1:0] qx, qy;
    logic                          ev [N_EDGES];

    // Stage 1: differences
    logic                 s1_valid_reg;
    pip_ctrl_t            s1_ctrl_reg;
    logic                 s1_ev_reg     [N_EDGES];
    logic signed [D-1:0]  s1_dx_reg     [N_EDGES];
    logic signed [D-1:0]  s1_dy_reg     [N_EDGES];
    logic signed [D-1:0]  s1_rx_reg     [N_EDGES];
    logic signed [D-1:0]  s1_ry_reg     [N_EDGES];
    logic                 s1_strad_reg  [N_EDGES];
    logic signed [D-1:0]  s1_dx_next    [N_EDGES];
    logic signed [D-1:0]  s1_dy_next    [N_EDGES];
    logic signed [D-1:0]  s1_rx_next    [N_EDGES];
    logic signed [D-1:0]  s1_ry_next    [N_EDGES];
    logic                 s1_strad_next [N_EDGES];

    // Stage 2: products
    logic                 s2_valid_reg;
    pip_ctrl_t            s2_ctrl_reg;
    logic                 s2_ev_reg    [N_EDGES];
    logic                 s2_strad_reg [N_EDGES];
    logic                 s2_nondeg_reg[N_EDGES];
    logic                 s2_dypos_reg [N_EDGES];
    logic signed [P-1:0]  s2_dxdx_reg  [N_EDGES];
    logic signed [P-1:0]  s2_dydy_reg  [N_EDGES];
    logic signed [P-1:0]  s2_rxdx_reg  [N_EDGES];
    logic signed [P-1:0]  s2_rydy_reg  [N_EDGES];
    logic signed [P-1:0]  s2_rxdy_reg  [N_EDGES];
    logic signed [P-1:0]  s2_rydx_reg  [N_EDGES];

    // Stage 3: decisions
    logic signed [S-1:0]  lensq   [N_EDGES];
    logic signed [S-1:0]  dot     [N_EDGES];
    logic                 hit     [N_EDGES];
    logic                 crosses [N_EDGES];

    // Accumulators and result register
    logic parity_reg, parity_next;
    logic bound_reg,  bound_next;
    logic out_valid_reg, out_valid_next;
    logic out_inside_reg, out_inside_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = q_valid && en;

    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;

    // Unpack the task word into the opening and closing edges
    always_comb
    begin
        qx = q_coords[C_QX*COORD_WIDTH +: COORD_WIDTH];
        qy = q_coords[C_QY*COORD_WIDTH +: COORD_WIDTH];
        x1[EDGE_OPEN]  = q_coords[C_PX*COORD_WIDTH +: COORD_WIDTH];
        y1[EDGE_OPEN]  = q_coords[C_PY*COORD_WIDTH +: COORD_WIDTH];
        x2[EDGE_OPEN]  = q_coords[C_VX*COORD_WIDTH +: COORD_WIDTH];
        y2[EDGE_OPEN]  = q_coords[C_VY*COORD_WIDTH +: COORD_WIDTH];
        x1[EDGE_CLOSE] = q_coords[C_VX*COORD_WIDTH +: COORD_WIDTH];
        y1[EDGE_CLOSE] = q_coords[C_VY*COORD_WIDTH +: COORD_WIDTH];
        x2[EDGE_CLOSE] = q_coords[C_SX*COORD_WIDTH +: COORD_WIDTH];
        y2[EDGE_CLOSE] = q_coords[C_SY*COORD_WIDTH +: COORD_WIDTH];
        ev[EDGE_OPEN]  = q_ctrl.edge_a;
        ev[EDGE_CLOSE] = q_ctrl.edge_b;
    end

    // Stage 1 logic: edge and query offsets, ray straddle test
    always_comb
    begin
        for (int e = 0; e < N_EDGES; e++)
        begin
            s1_dx_next[e] = D'(x2[e]) - D'(x1[e]);
            s1_dy_next[e] = D'(y2[e]) - D'(y1[e]);
            s1_rx_next[e] = D'(qx) - D'(x1[e]);
            s1_ry_next[e] = D'(qy) - D'(y1[e]);
            s1_strad_next[e] = ((y1[e] <= qy) && (y2[e] > qy)) ||
                               ((y2[e] <= qy) && (y1[e] > qy));
        end
    end

    // Stage 3 logic: on-edge and crossing decisions
    always_comb
    begin
        for (int e = 0; e < N_EDGES; e++)
        begin
            lensq[e] = S'(s2_dxdx_reg[e]) + S'(s2_dydy_reg[e]);
            dot[e]   = S'(s2_rxdx_reg[e]) + S'(s2_rydy_reg[e]);
            hit[e]   = s2_ev_reg[e] && !s2_ctrl_reg.excl && s2_nondeg_reg[e] &&
                       (s2_rxdy_reg[e] == s2_rydx_reg[e]) &&
                       (dot[e] >= 0) && (dot[e] <= lensq[e]);
            crosses[e] = s2_ev_reg[e] && s2_strad_reg[e] &&
                         (s2_dypos_reg[e] ? (s2_rxdy_reg[e] < s2_rydx_reg[e])
                                          : (s2_rxdy_reg[e] > s2_rydx_reg[e]));
        end
    end

    // Accumulate and form the result word
    always_comb
    begin
        parity_next     = parity_reg;
        bound_next      = bound_reg;
        out_valid_next  = out_valid_reg;
        out_inside_next = out_inside_reg;
        if (en)
        begin
            out_valid_next = s2_valid_reg && s2_ctrl_reg.last;
            if (s2_valid_reg)
            begin
                parity_next = (s2_ctrl_reg.first ? 1'b0 : parity_reg) ^
                              crosses[EDGE_OPEN] ^ crosses[EDGE_CLOSE];
                bound_next  = (s2_ctrl_reg.first ? 1'b0 : bound_reg) |
                              hit[EDGE_OPEN] | hit[EDGE_CLOSE];
                out_inside_next = s2_ctrl_reg.count_ok && (parity_next || bound_next);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            bound_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                s1_valid_reg <= q_valid;
                s2_valid_reg <= s1_valid_reg;
            end
            parity_reg    <= parity_next;
            bound_reg     <= bound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        out_inside_reg <= out_inside_next;
        if (en)
        begin
            s1_ctrl_reg <= q_ctrl;
            s2_ctrl_reg <= s1_ctrl_reg;
            for (int e = 0; e < N_EDGES; e++)
            begin
                s1_ev_reg[e]    <= ev[e];
                s1_dx_reg[e]    <= s1_dx_next[e];
                s1_dy_reg[e]    <= s1_dy_next[e];
                s1_rx_reg[e]    <= s1_rx_next[e];
                s1_ry_reg[e]    <= s1_ry_next[e];
                s1_strad_reg[e] <= s1_strad_next[e];

                s2_ev_reg[e]     <= s1_ev_reg[e];
                s2_strad_reg[e]  <= s1_strad_reg[e];
                s2_nondeg_reg[e] <= (s1_dx_reg[e] != '0) || (s1_dy_reg[e] != '0);
                s2_dypos_reg[e]  <= (s1_dy_reg[e] > 0);
                s2_dxdx_reg[e]   <= P'(s1_dx_reg[e]) * P'(s1_dx_reg[e]);
                s2_dydy_reg[e]   <= P'(s1_dy_reg[e]) * P'(s1_dy_reg[e]);
                s2_rxdx_reg[e]   <= P'(s1_rx_reg[e]) * P'(s1_dx_reg[e]);
                s2_rydy_reg[e]   <= P'(s1_ry_reg[e]) * P'(s1_dy_reg[e]);
                s2_rxdy_reg[e]   <= P'(s1_rx_reg[e]) * P'(s1_dy_reg[e]);
                s2_rydx_reg[e]   <= P'(s1_ry_reg[e]) * P'(s1_dx_reg[e]);
            end
        end
    end

endmodule

@@ src/point_in_polygon_test.sv @@
// Point-in-polygon test, even-odd ray casting, one vertex word per cycle until a waiting result fills the queue.
// Throughput: one vertex word per cycle while result words are taken, set by the queue pop and the edge pipeline.
// Path: the last vertex word of a polygon passes the queue, the difference stage and the
// product stage, and is then accumulated into the result register that holds the result word.
// Reset: asynchronous, clears the polygon context, accumulators, queue and valids.
// Vertex words keep being accepted while a result waits, until the queue fills.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pip_vertex_if.sink   vertex,
    pip_result_if.source result
);

    localparam int QW = $bits(pip_ctrl_t) + N_COORDS * COORD_WIDTH;

    logic                            q_ready;
    logic                            push;
    pip_ctrl_t                       task_ctrl;
    logic [N_COORDS*COORD_WIDTH-1:0] task_coords;
    logic                            q_valid;
    logic [QW-1:0]                   q_data;
    pip_ctrl_t                       head_ctrl;
    logic [N_COORDS*COORD_WIDTH-1:0] head_coords;
    logic                            pop;
    logic                            out_valid;
    logic                            out_inside;

    assign vertex.ready = q_ready;

    // Front end
    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (vertex.valid),
        .q_ready          (q_ready),
        .vertex_x         (vertex.vertex_x),
        .vertex_y         (vertex.vertex_y),
        .query_x          (vertex.query_x),
        .query_y          (vertex.query_y),
        .exclude_boundary (vertex.exclude_boundary),
        .first_vertex     (vertex.first_vertex),
        .last_vertex      (vertex.last_vertex),
        .push             (push),
        .task_ctrl        (task_ctrl),
        .task_coords      (task_coords)
    );

    // Task queue
    pip_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  ({task_ctrl, task_coords}),
        .wr_ready (q_ready),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    assign head_ctrl   = q_data[QW-1 -: $bits(pip_ctrl_t)];
    assign head_coords = q_data[N_COORDS*COORD_WIDTH-1:0];

    // Back end
    pip_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ctrl     (head_ctrl),
        .q_coords   (head_coords),
        .pop        (pop),
        .out_ready  (result.ready),
        .out_valid  (out_valid),
        .out_inside (out_inside)
    );

    assign result.valid      = out_valid;
    assign result.inside_res = out_inside;

endmodule
